@@ src/ftds_pkg.sv @@
package ftds_pkg;

	localparam int unsigned IDX_W = 21;
	localparam logic [IDX_W-1:0] MAX_LEN = 21'd1048576;

	localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
	localparam logic [31:0] MAG_MASK   = 32'h7FFF_FFFF;
	localparam logic [31:0] INF_BITS   = 32'h7F80_0000;
	localparam logic [31:0] FLOOR_BITS = 32'h0DA2_4260;
	localparam logic [23:0] FLOOR_MANT = 24'hA2_4260;
	localparam logic [7:0]  FLOOR_EXP  = 8'd27;

	localparam int unsigned DIV_W = 58;
	localparam int unsigned QUO_W = 48;
	localparam logic [5:0] REL_STEPS  = 6'd32;
	localparam logic [5:0] MEAN_STEPS = 6'd48;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = 2;

	typedef struct packed {
		logic [31:0]      ulp;
		logic             sat;
		logic [63:0]      num;
		logic [DIV_W-1:0] dvsr;
		logic             both;
		logic             last;
	} item_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] rem;
		logic [QUO_W-1:0] low;
		logic [5:0]       steps;
		logic [DIV_W-1:0] dvsr;
	} div_req_t;

endpackage

@@ src/float_trace_diff_stats_top.sv @@
// Channel   Handshake                   Payload
// item      item_valid / item_stall     ref_value, dut_value, ref_active, dut_active, last
// report    report_valid / report_stall compared_count .. avg_ulp
//
// A compared finite pair goes through the divider for the relative error in the
// back end, which yields one quotient bit per cycle; other pairs skip it.
// A report with compared pairs also runs the mean division, and every report
// is then loaded into the output registers.
// Up to four items queue ahead of the back end, so item_stall rises only when
// the queue is full. Reset clears all totals; the first mismatch reads as -1.
module float_trace_diff_stats_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [31:0]        ref_value,
	input  logic [31:0]        dut_value,
	input  logic               ref_active,
	input  logic               dut_active,
	input  logic               last,
	output logic               report_valid,
	input  logic               report_stall,
	output logic [20:0]        compared_count,
	output logic [20:0]        mismatch_count,
	output logic [31:0]        max_ulp,
	output logic [31:0]        max_rel_error,
	output logic signed [20:0] first_bad_elem,
	output logic [47:0]        avg_ulp
);

	ftds_pkg::item_t front_item, head;
	logic full, empty, pop, push;

	assign item_stall = full;
	assign push       = item_valid && !full;

	ftds_front u_front (
		.ref_value  (ref_value),
		.dut_value  (dut_value),
		.ref_active (ref_active),
		.dut_active (dut_active),
		.last       (last),
		.item       (front_item)
	);

	ftds_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (front_item),
		.pop     (pop),
		.rd_item (head),
		.empty   (empty),
		.full    (full)
	);

	ftds_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.empty          (empty),
		.pop            (pop),
		.report_valid   (report_valid),
		.report_stall   (report_stall),
		.compared_count (compared_count),
		.mismatch_count (mismatch_count),
		.max_ulp        (max_ulp),
		.max_rel_error  (max_rel_error),
		.first_bad_elem (first_bad_elem),
		.avg_ulp        (avg_ulp)
	);

endmodule

@@ src/ftds_front.sv @@
module ftds_front (
	input  logic [31:0]    ref_value,
	input  logic [31:0]    dut_value,
	input  logic           ref_active,
	input  logic           dut_active,
	input  logic           last,
	output ftds_pkg::item_t item
);

	logic [31:0] ma, mb, big, lesser, map_a, map_b;
	logic [7:0]  e_l, e_s, k;
	logic [23:0] m_l, m_s, m_d;
	logic [63:0] lp;
	logic [61:0] sm, sp, mask;
	logic        sticky;
	logic [5:0]  r;
	logic [7:0]  r_wide;

	always_comb begin
		ma = ref_value & ftds_pkg::MAG_MASK;
		mb = dut_value & ftds_pkg::MAG_MASK;
		big    = (ma >= mb) ? ma : mb;
		lesser = (ma >= mb) ? mb : ma;

		// Subnormals share the exponent of the smallest normal.
		e_l = big[30:23];
		m_l = {(e_l != 8'd0), big[22:0]};
		if (e_l == 8'd0) begin
			e_l = 8'd1;
		end
		e_s = lesser[30:23];
		m_s = {(e_s != 8'd0), lesser[22:0]};
		if (e_s == 8'd0) begin
			e_s = 8'd1;
		end
		k = e_l - e_s;

		lp = {2'b00, m_l, 38'd0};
		sm = {m_s, 38'd0};
		if (k <= 8'd62) begin
			sp     = sm >> k;
			mask   = ~({62{1'b1}} << k);
			sticky = (sm & mask) != 62'd0;
		end else begin
			sp     = 62'd0;
			mask   = 62'd0;
			sticky = m_s != 24'd0;
		end

		if (((ref_value ^ dut_value) & ftds_pkg::SIGN_BIT) == 32'd0) begin
			item.num = lp - {2'b00, sp} - {63'd0, sticky};
		end else begin
			item.num = lp + {2'b00, sp};
		end

		if (big >= ftds_pkg::FLOOR_BITS) begin
			m_d    = m_l;
			r_wide = 8'd8;
		end else begin
			m_d    = ftds_pkg::FLOOR_MANT;
			r_wide = ftds_pkg::FLOOR_EXP - e_l + 8'd8;
		end
		r = r_wide[5:0];
		item.dvsr = {34'd0, m_d} << r;

		map_a = ref_value[31] ? ~ref_value : (ref_value | ftds_pkg::SIGN_BIT);
		map_b = dut_value[31] ? ~dut_value : (dut_value | ftds_pkg::SIGN_BIT);
		if (((ref_value | dut_value) & ftds_pkg::MAG_MASK) == 32'd0) begin
			item.ulp = 32'd0;
		end else begin
			item.ulp = (map_a > map_b) ? (map_a - map_b) : (map_b - map_a);
		end

		item.sat  = (ma >= ftds_pkg::INF_BITS) || (mb >= ftds_pkg::INF_BITS);
		item.both = ref_active & dut_active;
		item.last = last;
	end

endmodule

@@ src/ftds_fifo.sv @@
module ftds_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ftds_pkg::item_t wr_item,
	input  logic            pop,
	output ftds_pkg::item_t rd_item,
	output logic            empty,
	output logic            full
);

	ftds_pkg::item_t entry_q [ftds_pkg::FIFO_DEPTH];
	logic [ftds_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [ftds_pkg::FIFO_AW:0]   count_q;

	assign empty   = count_q == '0;
	assign full    = count_q == (ftds_pkg::FIFO_AW+1)'(ftds_pkg::FIFO_DEPTH);
	assign rd_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ src/ftds_div.sv @@
module ftds_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ftds_pkg::div_req_t             req,
	output logic                           done,
	output logic [ftds_pkg::QUO_W-1:0]     quo
);

	logic [ftds_pkg::DIV_W-1:0] rem_q, dvsr_q;
	logic [ftds_pkg::QUO_W-1:0] low_q, quo_q;
	logic [5:0]                 cnt_q;
	logic                       run_q, done_q;
	logic [ftds_pkg::DIV_W:0]   trial, diff;
	logic                       ge;

	// Restoring division, one quotient bit per cycle. The caller preloads the
	// upper dividend bits that are known to be below the divisor.
	always_comb begin
		trial = {rem_q, low_q[ftds_pkg::QUO_W-1]};
		ge    = trial >= {1'b0, dvsr_q};
		diff  = trial - {1'b0, dvsr_q};
	end

	assign done = done_q;
	assign quo  = quo_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.rem;
			low_q  <= req.low;
			dvsr_q <= req.dvsr;
			quo_q  <= '0;
		end else if (run_q) begin
			rem_q <= ge ? diff[ftds_pkg::DIV_W-1:0] : trial[ftds_pkg::DIV_W-1:0];
			low_q <= {low_q[ftds_pkg::QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[ftds_pkg::QUO_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= req.steps;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ src/ftds_back.sv @@
module ftds_back (
	input  logic            clk,
	input  logic            arst_n,
	input  ftds_pkg::item_t head,
	input  logic            empty,
	output logic            pop,
	output logic            report_valid,
	input  logic            report_stall,
	output logic [20:0]     compared_count,
	output logic [20:0]     mismatch_count,
	output logic [31:0]     max_ulp,
	output logic [31:0]     max_rel_error,
	output logic signed [20:0] first_bad_elem,
	output logic [47:0]     avg_ulp
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHK  = 3'd1;
	localparam logic [2:0] S_REL  = 3'd2;
	localparam logic [2:0] S_FIN  = 3'd3;
	localparam logic [2:0] S_MEAN = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0] state_q;
	ftds_pkg::item_t cur_q;
	logic cmp_q;

	logic [20:0] idx_q, cnt_q, mis_q, first_q;
	logic [31:0] maxu_q, maxr_q;
	logic [51:0] acc_q;
	logic [47:0] mean_q;

	ftds_pkg::div_req_t req;
	logic        div_done;
	logic [47:0] div_quo;

	logic        upd_en, load_out, clear_stats;
	logic [31:0] upd_rel;

	ftds_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign load_out = (state_q == S_OUT) && (!report_valid || !report_stall);
	assign clear_stats = load_out;
	assign pop = (state_q == S_IDLE) && !empty;

	always_comb begin
		req         = '0;
		upd_en      = 1'b0;
		upd_rel     = 32'hFFFF_FFFF;
		unique case (state_q)
			S_CHK: begin
				if (cmp_q && !cur_q.sat) begin
					req.start = 1'b1;
					req.rem   = {26'd0, cur_q.num[63:32]};
					req.low   = {cur_q.num[31:0], 16'd0};
					req.steps = ftds_pkg::REL_STEPS;
					req.dvsr  = cur_q.dvsr;
				end else begin
					upd_en = 1'b1;
				end
			end
			S_REL: begin
				upd_en  = div_done;
				upd_rel = div_quo[31:0];
			end
			S_FIN: begin
				if (cur_q.last && cnt_q != 21'd0) begin
					req.start = 1'b1;
					req.rem   = {38'd0, acc_q[51:32]};
					req.low   = {acc_q[31:0], 16'd0};
					req.steps = ftds_pkg::MEAN_STEPS;
					req.dvsr  = {37'd0, cnt_q};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (state_q == S_MEAN && div_done) begin
			mean_q <= div_quo;
		end else if (state_q == S_FIN) begin
			mean_q <= '0;
		end
		if (load_out) begin
			compared_count <= cnt_q;
			mismatch_count <= mis_q;
			max_ulp        <= maxu_q;
			max_rel_error  <= maxr_q;
			first_bad_elem <= first_q;
			avg_ulp        <= mean_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmp_q        <= 1'b0;
			report_valid <= 1'b0;
			idx_q        <= '0;
			cnt_q        <= '0;
			mis_q        <= '0;
			maxu_q       <= '0;
			maxr_q       <= '0;
			first_q      <= '1;
			acc_q        <= '0;
		end else begin
			if (load_out) begin
				report_valid <= 1'b1;
			end else if (!report_stall) begin
				report_valid <= 1'b0;
			end

			if (clear_stats) begin
				idx_q   <= '0;
				cnt_q   <= '0;
				mis_q   <= '0;
				maxu_q  <= '0;
				maxr_q  <= '0;
				first_q <= '1;
				acc_q   <= '0;
			end else if (upd_en) begin
				// Elements past the length limit leave every total untouched.
				if (idx_q < ftds_pkg::MAX_LEN) begin
					idx_q <= idx_q + 1'b1;
				end
				if (cmp_q) begin
					cnt_q <= cnt_q + 1'b1;
					acc_q <= acc_q + {20'd0, cur_q.ulp};
					if (cur_q.ulp > maxu_q) begin
						maxu_q <= cur_q.ulp;
					end
					if (upd_rel > maxr_q) begin
						maxr_q <= upd_rel;
					end
					if (cur_q.ulp != 32'd0) begin
						mis_q <= mis_q + 1'b1;
						if (first_q[20]) begin
							first_q <= idx_q;
						end
					end
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						cmp_q   <= head.both && (idx_q < ftds_pkg::MAX_LEN);
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					state_q <= req.start ? S_REL : S_FIN;
				end
				S_REL: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!cur_q.last) begin
						state_q <= S_IDLE;
					end else if (req.start) begin
						state_q <= S_MEAN;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_MEAN: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ src/ftds_checker.sv @@
module ftds_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        report_valid,
	input logic        report_stall,
	input logic [20:0] compared_count,
	input logic [20:0] mismatch_count,
	input logic [31:0] max_ulp,
	input logic [47:0] avg_ulp
);

	// A stalled report must stay valid and hold its compared count and mean ULP until the transaction completes.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && report_stall |=> report_valid && $stable(compared_count)
			&& $stable(avg_ulp))
		else $error("report changed while stalled");

	a_mis_le_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid |-> mismatch_count <= compared_count)
		else $error("more mismatches than compared pairs");

	a_no_mis_max: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && mismatch_count == 21'd0 |-> max_ulp == 32'd0)
		else $error("nonzero max ULP without a mismatch");

	a_empty_mean: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && compared_count == 21'd0 |-> avg_ulp == 48'd0)
		else $error("nonzero mean with nothing compared");

endmodule

bind float_trace_diff_stats_top ftds_checker u_ftds_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.report_valid   (report_valid),
	.report_stall   (report_stall),
	.compared_count (compared_count),
	.mismatch_count (mismatch_count),
	.max_ulp        (max_ulp),
	.avg_ulp        (avg_ulp)
);
